>>> rtl/csvlfs_pkg.sv
`default_nettype none
package csvlfs_pkg;

    // parameter defaults
    localparam int MAX_FIELD_COUNT_DEF = 64;
    localparam int MAX_LINE_LEN_DEF    = 4096;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // result port widths
    localparam int IDX_W = 6;
    localparam int OFF_W = 13;
    localparam int LEN_W = 13;
    localparam int CNT_W = 7;

    // byte codes
    localparam logic [7:0] QUOTE_CH = 8'h22;
    localparam logic [7:0] COMMA_CH = 8'h2C;

    // input word kinds
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_EOL  = 1'b1;

    // result word kinds
    localparam logic KIND_FIELD   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // scanner modes
    typedef enum logic [3:0] {
        MODE_START  = 4'b0001,
        MODE_UNQ    = 4'b0010,
        MODE_QUOTED = 4'b0100,
        MODE_QPEND  = 4'b1000
    } mode_t;

    // one queue entry: up to one field word and one summary word
    typedef struct packed {
        logic             has_field;
        logic             has_sum;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
    } entry_t;

endpackage
`default_nettype wire

>>> rtl/csv_line_field_splitter.sv
`default_nettype none
// CSV line field splitter. Feed one line a byte at a time (req_type 0) and close it with
// an end-of-line word (req_type 1). Each field comes out as one result word with its
// index, offset of the first content byte and raw length (quotes of a quoted field not
// counted, doubled quotes counted as two); end of line adds a summary word with the field
// count and the overflow flag, and "last" marks the final word caused by an input word.
// Input takes one word every cycle while full is low: the scanner updates its line state
// for each byte and hands its results to a QUEUE_DEPTH entry queue. The result side
// drains one word per cycle while pop is high, so an end of line that closes an open
// field needs two pops; full rises only when the queue of pending entries is full. Each entry
// is registered in the queue before output. No clearing pass follows reset.
module csv_line_field_splitter
    import csvlfs_pkg::*;
#(
    parameter int MAX_FIELD_COUNT = MAX_FIELD_COUNT_DEF,
    parameter int MAX_LINE_LEN    = MAX_LINE_LEN_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic             req_type,
    input  wire logic [7:0]       char_byte,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  result_kind,
    output logic [IDX_W-1:0]      field_index,
    output logic [OFF_W-1:0]      field_offset,
    output logic [LEN_W-1:0]      field_length,
    output logic [CNT_W-1:0]      line_field_count,
    output logic                  line_overflow,
    output logic                  last
);

    entry_t ent;
    entry_t head;
    logic   ent_push;
    logic   accept;
    logic   q_empty;
    logic   q_pop;

    assign accept = push & ~full;

    // front: byte scanner
    csvlfs_scanner #(
        .MAX_FIELD_COUNT (MAX_FIELD_COUNT),
        .MAX_LINE_LEN    (MAX_LINE_LEN)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req_type  (req_type),
        .char_byte (char_byte),
        .ent       (ent),
        .ent_push  (ent_push)
    );

    // entry queue between the two sides
    csvlfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ent_push),
        .wr_data (ent),
        .full    (full),
        .empty   (q_empty),
        .rd_en   (q_pop),
        .rd_data (head)
    );

    // back: result word sequencing
    csvlfs_emitter u_emitter (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .pop              (pop),
        .empty            (empty),
        .result_kind      (result_kind),
        .field_index      (field_index),
        .field_offset     (field_offset),
        .field_length     (field_length),
        .line_field_count (line_field_count),
        .line_overflow    (line_overflow),
        .last             (last)
    );

endmodule
`default_nettype wire

>>> rtl/csvlfs_scanner.sv
`default_nettype none
module csvlfs_scanner
    import csvlfs_pkg::*;
#(
    parameter int MAX_FIELD_COUNT = MAX_FIELD_COUNT_DEF,
    parameter int MAX_LINE_LEN    = MAX_LINE_LEN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       req_type,
    input  wire logic [7:0] char_byte,
    output entry_t          ent,
    output logic            ent_push
);

    localparam int POS_W = $clog2(MAX_LINE_LEN + 1);
    localparam int FC_W  = $clog2(MAX_FIELD_COUNT + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE_LEN);
    localparam logic [FC_W-1:0]  FC_MAX  = FC_W'(MAX_FIELD_COUNT);

    mode_t            mode_reg,  mode_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [FC_W-1:0]  found_reg, found_next;
    logic             comma_reg, comma_next;
    logic             ovf_reg,   ovf_next;

    logic             emit;
    logic [POS_W-1:0] e_off;
    logic [POS_W-1:0] e_len;
    logic [POS_W-1:0] pos_dec;
    logic [FC_W-1:0]  found_inc;
    logic             room;

    function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] e,
                                              input logic [POS_W-1:0] s);
        span = (e > s) ? e - s : '0;
    endfunction

    assign pos_dec   = (pos_reg == '0) ? '0 : pos_reg - 1'b1;
    assign found_inc = found_reg + 1'b1;
    assign room      = found_reg < FC_MAX;

    // next state and result words
    always_comb
    begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        found_next = found_reg;
        comma_next = comma_reg;
        ovf_next   = ovf_reg;
        emit       = 1'b0;
        e_off      = '0;
        e_len      = '0;
        ent        = '0;
        if (accept)
        begin
            if (req_type == REQ_DATA)
            begin
                if (pos_reg == POS_MAX)
                    ovf_next = 1'b1;
                else
                    pos_next = pos_reg + 1'b1;
                if (room)
                begin
                    case (mode_reg)
                        MODE_START:
                        begin
                            comma_next = 1'b0;
                            if (char_byte == QUOTE_CH)
                            begin
                                start_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 1'b1;
                                mode_next  = MODE_QUOTED;
                            end
                            else if (char_byte == COMMA_CH)
                            begin
                                emit       = 1'b1;
                                e_off      = pos_reg;
                                comma_next = 1'b1;
                            end
                            else
                            begin
                                start_next = pos_reg;
                                mode_next  = MODE_UNQ;
                            end
                        end
                        MODE_UNQ:
                        begin
                            if (char_byte == COMMA_CH)
                            begin
                                emit       = 1'b1;
                                e_off      = start_reg;
                                e_len      = span(pos_reg, start_reg);
                                comma_next = 1'b1;
                                mode_next  = MODE_START;
                            end
                        end
                        MODE_QUOTED:
                        begin
                            if (char_byte == QUOTE_CH)
                                mode_next = MODE_QPEND;
                        end
                        MODE_QPEND:
                        begin
                            if (char_byte == QUOTE_CH)
                                mode_next = MODE_QUOTED;
                            else
                            begin
                                emit  = 1'b1;
                                e_off = start_reg;
                                e_len = span(pos_dec, start_reg);
                                if (char_byte == COMMA_CH)
                                begin
                                    comma_next = 1'b1;
                                    mode_next  = MODE_START;
                                end
                                else if (found_inc < FC_MAX)
                                begin
                                    comma_next = 1'b0;
                                    start_next = pos_reg;
                                    mode_next  = MODE_UNQ;
                                end
                                else
                                    mode_next = MODE_START;
                            end
                        end
                        default:
                            mode_next = MODE_START;
                    endcase
                end
                if (emit)
                    found_next = found_inc;
            end
            else
            begin
                // end of line: close the open field, then the summary
                if (room)
                begin
                    case (mode_reg)
                        MODE_UNQ, MODE_QUOTED:
                        begin
                            emit  = 1'b1;
                            e_off = start_reg;
                            e_len = span(pos_reg, start_reg);
                        end
                        MODE_QPEND:
                        begin
                            emit  = 1'b1;
                            e_off = start_reg;
                            e_len = span(pos_dec, start_reg);
                        end
                        default:
                        begin
                            emit  = comma_reg;
                            e_off = pos_reg;
                        end
                    endcase
                end
                ent.has_sum = 1'b1;
                ent.cnt     = emit ? CNT_W'(found_inc) : CNT_W'(found_reg);
                ent.ovf     = ovf_reg;
                mode_next   = MODE_START;
                pos_next    = '0;
                start_next  = '0;
                found_next  = '0;
                comma_next  = 1'b0;
                ovf_next    = 1'b0;
            end
        end
        ent.has_field = emit;
        ent.idx       = emit ? IDX_W'(found_reg) : '0;
        ent.off       = OFF_W'(e_off);
        ent.len       = LEN_W'(e_len);
    end

    assign ent_push = ent.has_field | ent.has_sum;

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            pos_reg   <= '0;
            start_reg <= '0;
            found_reg <= '0;
            comma_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            found_reg <= found_next;
            comma_reg <= comma_next;
            ovf_reg   <= ovf_next;
        end
    end

    // position saturates, field count stops at the limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte position past line limit");

    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FC_MAX)
        else $error("field count past limit");

endmodule
`default_nettype wire

>>> rtl/csvlfs_queue.sv
`default_nettype none
module csvlfs_queue
    import csvlfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire entry_t wr_data,
    output logic        full,
    output logic        empty,
    input  wire logic   rd_en,
    output entry_t      rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTR_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CTR_W-1:0] CTR_FULL = CTR_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CTR_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = cnt_reg == CTR_FULL;
    assign empty   = cnt_reg == '0;
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // the front only writes when there is room
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("entry written into full queue");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fill count did not follow write");

endmodule
`default_nettype wire

>>> rtl/csvlfs_emitter.sv
`default_nettype none
module csvlfs_emitter
    import csvlfs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire entry_t            head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output logic                   result_kind,
    output logic [IDX_W-1:0]       field_index,
    output logic [OFF_W-1:0]       field_offset,
    output logic [LEN_W-1:0]       field_length,
    output logic [CNT_W-1:0]       line_field_count,
    output logic                   line_overflow,
    output logic                   last
);

    logic phase_reg, phase_next;
    logic both;
    logic sel_sum;
    logic take;

    assign both    = head.has_field & head.has_sum;
    assign sel_sum = ~head.has_field | phase_reg;
    assign take    = pop & ~q_empty;
    assign empty   = q_empty;

    // word on the result ports
    assign result_kind      = sel_sum ? KIND_SUMMARY : KIND_FIELD;
    assign field_index      = sel_sum ? '0 : head.idx;
    assign field_offset     = sel_sum ? '0 : head.off;
    assign field_length     = sel_sum ? '0 : head.len;
    assign line_field_count = sel_sum ? head.cnt : '0;
    assign line_overflow    = sel_sum ? head.ovf : 1'b0;
    assign last             = sel_sum | ~head.has_sum;

    // a two-word entry is drained field first, then summary
    always_comb
    begin
        phase_next = phase_reg;
        q_pop      = 1'b0;
        if (take)
        begin
            if (both && !phase_reg)
                phase_next = 1'b1;
            else
            begin
                phase_next = 1'b0;
                q_pop      = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= 1'b0;
        else
            phase_reg <= phase_next;
    end

    // second phase only ever sits on a two-word entry
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (!q_empty && both))
        else $error("summary phase without a two-word entry");

endmodule
`default_nettype wire

>>> bench/csv_line_field_splitter_tb.sv
`timescale 1ns / 1ps

module csv_line_field_splitter_tb;
    import csvlfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CHUNK_WORDS    = 180;
    localparam int PRINT_LIMIT    = 60;

    // one word toward the block: a line byte or an end of line
    typedef struct packed {
        logic       rt;
        logic [7:0] ch;
    } line_word_t;

    // one result word as it should appear on the result ports
    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
        logic             last;
    } split_result_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic             req_type  = 1'b0;
    logic [7:0]       char_byte = 8'h00;
    logic             pop       = 1'b0;
    logic             full;
    logic             empty;
    logic             result_kind;
    logic [IDX_W-1:0] field_index;
    logic [OFF_W-1:0] field_offset;
    logic [LEN_W-1:0] field_length;
    logic [CNT_W-1:0] line_field_count;
    logic             line_overflow;
    logic             last;

    csv_line_field_splitter #(
        .MAX_FIELD_COUNT (MAX_FIELD_COUNT_DEF),
        .MAX_LINE_LEN    (MAX_LINE_LEN_DEF),
        .QUEUE_DEPTH     (QUEUE_DEPTH_DEF)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .req_type         (req_type),
        .char_byte        (char_byte),
        .empty            (empty),
        .pop              (pop),
        .result_kind      (result_kind),
        .field_index      (field_index),
        .field_offset     (field_offset),
        .field_length     (field_length),
        .line_field_count (line_field_count),
        .line_overflow    (line_overflow),
        .last             (last)
    );

    // words waiting to be sent and results still to come
    line_word_t    line_bytes[$];
    split_result_t awaited_results[$];
    line_word_t    next_word;

    // handshake bookkeeping
    logic word_accepted = 1'b0;
    logic result_taken  = 1'b0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    int   sender_gap_max     = 9;
    int   receiver_stall_max = 9;
    int   idle_cycles   = 0;

    // run statistics
    int error_count     = 0;
    int results_checked = 0;
    int words_taken     = 0;
    int queued_words    = 0;
    int lines_closed    = 0;
    int overflow_lines  = 0;
    int capped_lines    = 0;

    // line scanner state of the prediction
    mode_t       scan_mode   = MODE_START;
    int unsigned line_pos    = 0;
    int unsigned field_start = 0;
    int unsigned found       = 0;
    bit          comma_seen  = 1'b0;
    bit          line_ovf    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int unsigned span(int unsigned stop, int unsigned from);
        return (stop > from) ? stop - from : 0;
    endfunction

    task automatic report_error(string msg);
        if (error_count < PRINT_LIMIT)
            $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    // append one expected result word
    task automatic expect_word(split_result_t r);
        awaited_results.insert(awaited_results.size(), r);
    endtask

    // queue one field word and bump the field count
    task automatic add_field(int unsigned off, int unsigned len, logic is_last);
        split_result_t r;
        r      = '0;
        r.kind = KIND_FIELD;
        r.idx  = IDX_W'(found);
        r.off  = OFF_W'(off);
        r.len  = LEN_W'(len);
        r.last = is_last;
        expect_word(r);
        found++;
    endtask

    // work out the result words caused by one accepted word
    task automatic scan_word(logic rt, logic [7:0] ch);
        int unsigned   p;
        split_result_t sum;
        if (rt == REQ_DATA)
        begin
            p = line_pos;
            if (p < MAX_LINE_LEN_DEF)
                line_pos = p + 1;
            else
                line_ovf = 1'b1;
            if (found < MAX_FIELD_COUNT_DEF)
            begin
                case (scan_mode)
                    MODE_START:
                    begin
                        comma_seen = 1'b0;
                        if (ch == QUOTE_CH)
                        begin
                            field_start = (p + 1 > MAX_LINE_LEN_DEF) ? MAX_LINE_LEN_DEF : p + 1;
                            scan_mode = MODE_QUOTED;
                        end
                        else if (ch == COMMA_CH)
                        begin
                            add_field(p, 0, 1'b1);
                            comma_seen = 1'b1;
                        end
                        else
                        begin
                            field_start = p;
                            scan_mode = MODE_UNQ;
                        end
                    end
                    MODE_UNQ:
                    begin
                        if (ch == COMMA_CH)
                        begin
                            add_field(field_start, span(p, field_start), 1'b1);
                            comma_seen = 1'b1;
                            scan_mode = MODE_START;
                        end
                    end
                    MODE_QUOTED:
                    begin
                        if (ch == QUOTE_CH)
                            scan_mode = MODE_QPEND;
                    end
                    default:
                    begin
                        // quote seen: a second quote is an escape, anything else closes
                        if (ch == QUOTE_CH)
                            scan_mode = MODE_QUOTED;
                        else
                        begin
                            add_field(field_start, span((p > 0) ? p - 1 : 0, field_start), 1'b1);
                            if (ch == COMMA_CH)
                            begin
                                comma_seen = 1'b1;
                                scan_mode = MODE_START;
                            end
                            else if (found < MAX_FIELD_COUNT_DEF)
                            begin
                                comma_seen = 1'b0;
                                field_start = p;
                                scan_mode = MODE_UNQ;
                            end
                            else
                                scan_mode = MODE_START;
                        end
                    end
                endcase
            end
        end
        else
        begin
            // end of line: close the open field, then the summary
            if (found < MAX_FIELD_COUNT_DEF)
            begin
                if (scan_mode == MODE_UNQ || scan_mode == MODE_QUOTED)
                    add_field(field_start, span(line_pos, field_start), 1'b0);
                else if (scan_mode == MODE_QPEND)
                    add_field(field_start,
                              span((line_pos > 0) ? line_pos - 1 : 0, field_start), 1'b0);
                else if (comma_seen)
                    add_field(line_pos, 0, 1'b0);
            end
            sum      = '0;
            sum.kind = KIND_SUMMARY;
            sum.cnt  = CNT_W'(found);
            sum.ovf  = line_ovf;
            sum.last = 1'b1;
            expect_word(sum);
            lines_closed++;
            if (line_ovf)
                overflow_lines++;
            if (found >= MAX_FIELD_COUNT_DEF)
                capped_lines++;
            scan_mode   = MODE_START;
            line_pos    = 0;
            field_start = 0;
            found       = 0;
            comma_seen  = 1'b0;
            line_ovf    = 1'b0;
        end
    endtask

    task automatic check_field(string name, logic [12:0] got, logic [12:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_checked, name, got, want));
    endtask

    // compare the word on the result ports with the oldest expectation
    task automatic check_result();
        split_result_t want;
        if (awaited_results.size() == 0)
            report_error($sformatf("result %0d arrived with nothing awaited (kind %0d index %0d)",
                                   results_checked, result_kind, field_index));
        else
        begin
            want = awaited_results.pop_front();
            check_field("result_kind", 13'(result_kind), 13'(want.kind));
            check_field("field_index", 13'(field_index), 13'(want.idx));
            check_field("field_offset", 13'(field_offset), 13'(want.off));
            check_field("field_length", 13'(field_length), 13'(want.len));
            check_field("line_field_count", 13'(line_field_count), 13'(want.cnt));
            check_field("line_overflow", 13'(line_overflow), 13'(want.ovf));
            check_field("last", 13'(last), 13'(want.last));
        end
        results_checked++;
    endtask

    // sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        word_accepted <= push && !full;
        result_taken  <= pop && !empty;
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (push && !full)
        begin
            scan_word(req_type, char_byte);
            words_taken++;
        end
        if (pop && !empty)
            check_result();
    end

    // sender: one word at a time, random gap after each
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || word_accepted)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end
            else if (line_bytes.size() > 0)
            begin
                next_word = line_bytes.pop_front();
                push      <= 1'b1;
                req_type  <= next_word.rt;
                char_byte <= next_word.ch;
                gap_left  <= $urandom_range(0, sender_gap_max);
            end
            else
                push <= 1'b0;
        end
    end

    // receiver: random stall before each result word
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (result_taken)
                stall_left = $urandom_range(0, receiver_stall_max);
            if (!empty && stall_left > 0)
            begin
                stall_left = stall_left - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog on a stuck handshake
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, awaited_results.size());
        $display("simulation failed");
        $finish;
    end

    task automatic add_byte(logic [7:0] ch);
        line_word_t w;
        w = '{REQ_DATA, ch};
        line_bytes.insert(line_bytes.size(), w);
        queued_words++;
    endtask

    task automatic add_eol();
        line_word_t w;
        w = '{REQ_EOL, 8'($urandom_range(0, 255))};
        line_bytes.insert(line_bytes.size(), w);
        queued_words++;
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    // any byte but a quote or a comma
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == QUOTE_CH || b == COMMA_CH);
        return b;
    endfunction

    // well-formed line: plain, empty and quoted fields, maybe a trailing comma
    task automatic add_wellformed_line();
        int n_fields;
        n_fields = $urandom_range(0, 8);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                add_byte(COMMA_CH);
            case ($urandom_range(0, 3))
                0: ;
                1, 2:
                    repeat ($urandom_range(1, 6)) add_byte(plain_byte());
                default:
                begin
                    add_byte(QUOTE_CH);
                    repeat ($urandom_range(0, 6))
                    begin
                        case ($urandom_range(0, 5))
                            0:
                            begin
                                add_byte(QUOTE_CH);
                                add_byte(QUOTE_CH);
                            end
                            1: add_byte(COMMA_CH);
                            default: add_byte(plain_byte());
                        endcase
                    end
                    add_byte(QUOTE_CH);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            add_byte(COMMA_CH);
        add_eol();
    endtask

    // noise line rich in quotes and commas
    task automatic add_noise_line();
        repeat ($urandom_range(0, 16))
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: add_byte(QUOTE_CH);
                3, 4: add_byte(COMMA_CH);
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        add_eol();
    endtask

    // at least as many fields as the cap allows, some split by junk after a closing quote
    task automatic add_crowded_line();
        int n_fields;
        n_fields = $urandom_range(MAX_FIELD_COUNT_DEF, MAX_FIELD_COUNT_DEF + 10);
        for (int f = 0; f < n_fields; f++)
        begin
            if (f > 0)
                add_byte(COMMA_CH);
            case ($urandom_range(0, 3))
                0: ;
                1: add_byte(plain_byte());
                2:
                begin
                    add_byte(QUOTE_CH);
                    add_byte(plain_byte());
                    add_byte(QUOTE_CH);
                end
                default: add_text("\"q\"z");
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            add_byte(COMMA_CH);
        add_eol();
    endtask

    // line past the length limit, with a noisy tail beyond it
    task automatic add_long_line(bit open_quote_at_end);
        int body;
        int run_len;
        body = 0;
        while (body < MAX_LINE_LEN_DEF - 8)
        begin
            run_len = $urandom_range(100, 300);
            repeat (run_len) add_byte(plain_byte());
            add_byte(COMMA_CH);
            body += run_len + 1;
        end
        repeat (24)
        begin
            case ($urandom_range(0, 3))
                0: add_byte(QUOTE_CH);
                1: add_byte(COMMA_CH);
                default: add_byte(plain_byte());
            endcase
        end
        if (open_quote_at_end)
        begin
            add_byte(QUOTE_CH);
            add_text("tail");
        end
        add_eol();
    endtask

    // hold until every word is sent and every result is back
    task automatic wait_drained();
        while (line_bytes.size() > 0 || push || awaited_results.size() > 0)
            @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        int start_words;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed lines: doubled quote, junk after a closing quote, trailing comma
        add_text("a,\"b\"\"c\"x,");
        add_eol();
        // empty line
        add_eol();
        // unterminated quote
        add_text("\"ab");
        add_eol();
        // closing quote right before end of line
        add_text("\"q\"");
        add_eol();
        // byte extremes
        add_byte(8'h00);
        add_byte(8'hFF);
        add_eol();
        // lone comma: empty field plus trailing empty field
        add_byte(COMMA_CH);
        add_eol();
        wait_drained();

        // random lines in chunks with varying idle patterns
        for (int chunk = 0; chunk < 6; chunk++)
        begin
            sender_gap_max     = (chunk % 3 == 1) ? 0 : 9;
            receiver_stall_max = (chunk % 3 == 2) ? 0 : 9;
            start_words = queued_words;
            if (chunk == 2 || chunk == 4)
                add_crowded_line();
            while (queued_words - start_words < CHUNK_WORDS)
            begin
                if ($urandom_range(0, 9) < 8)
                    add_wellformed_line();
                else
                    add_noise_line();
            end
            if (chunk == 0 || $urandom_range(0, 1) == 1)
                wait_drained();
            else
                while (line_bytes.size() > 0)
                    @(negedge clk);
        end

        // over-long lines at full input rate
        sender_gap_max     = 0;
        receiver_stall_max = 9;
        add_long_line(1'b0);
        add_long_line(1'b1);
        wait_drained();
        repeat (8) @(negedge clk);

        $display("sent %0d words in %0d lines, checked %0d result words",
                 words_taken, lines_closed, results_checked);
        $display("%0d lines reached the field cap, %0d lines ran past the length limit",
                 capped_lines, overflow_lines);
        if (error_count == 0 && awaited_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
rtl/csvlfs_pkg.sv
rtl/csvlfs_scanner.sv
rtl/csvlfs_queue.sv
rtl/csvlfs_emitter.sv
rtl/csv_line_field_splitter.sv
bench/csv_line_field_splitter_tb.sv
